[src/vcsl_pkg.sv]
// ----------------------------------------------------------------------------
// vcsl_pkg
// Shared types and constants for the velocity command slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package vcsl_pkg;

  // Item fields
  localparam int CMD_W   = 16;
  localparam int TIME_W  = 32;
  localparam int VEL_W   = 17;
  localparam int NUM_AX  = 3;

  localparam int IN_TDATA_W  = TIME_W + NUM_AX * CMD_W;          // 80
  localparam int OUT_FIELD_W = NUM_AX * VEL_W;                   // 51
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;      // 56

  // Configuration register fields
  localparam int EN_W    = 2;
  localparam int MAX_W   = 16;
  localparam int RATE_W  = 24;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 3;

  // Step limit datapath
  localparam int NUM_LANE = 4;
  localparam int DT_W     = 31;
  localparam int LO_W     = 16;
  localparam int HI_W     = DT_W - LO_W;
  localparam int PLO_W    = RATE_W + LO_W;
  localparam int PHI_W    = RATE_W + HI_W;
  localparam int PROD_W   = RATE_W + DT_W;
  localparam int X_W      = 31;
  localparam int LIM_W    = 18;
  localparam int RQ_W     = X_W + LIM_W;

  localparam logic [DT_W-1:0]  NOMINAL_PERIOD_US = 31'd20000;
  // floor(2^31 / 15625); quotient estimate is low by at most one
  localparam logic [LIM_W-1:0] RECIP_DIV   = 18'd137438;
  localparam logic [13:0]      DIV_CONST   = 14'd15625;
  localparam logic [LIM_W-1:0] LIM_SAT     = 18'd131072;
  localparam logic [16:0]      ONE_Q14     = 17'd16384;

  // Lane order of the step limits (matches register order)
  localparam int LANE_LIN_ACC = 0;
  localparam int LANE_LIN_DEC = 1;
  localparam int LANE_ANG_ACC = 2;
  localparam int LANE_ANG_DEC = 3;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ENABLE_FLAGS = 3'd0,
    REG_TIMEOUT_US   = 3'd1,
    REG_MAX_LINEAR   = 3'd2,
    REG_MAX_ANGULAR  = 3'd3,
    REG_LIN_ACCEL    = 3'd4,
    REG_LIN_DECEL    = 3'd5,
    REG_ANG_ACCEL    = 3'd6,
    REG_ANG_DECEL    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_COMMAND = 1'b0,
    KIND_TICK    = 1'b1
  } kind_t;

endpackage

`default_nettype wire

[src/velocity_command_slew_limiter_unit.sv]
// ----------------------------------------------------------------------------
// velocity_command_slew_limiter_unit
// Holds the latest three-axis velocity command and, on each control tick,
// emits a timeout-gated, scaled and rate-limited Q8.8 velocity.
// ----------------------------------------------------------------------------
// Accepts one item per clock. A command item (tuser = 0) only updates the held
// command and produces no result. A tick item (tuser = 1) produces exactly one
// result, and out_tvalid rises once it has passed the whole pipeline: the tick
// enters an input stage on the transfer edge, then goes through partial
// products of rate x dt, their sum, a reciprocal multiply for the divide by
// 1e6, a remainder correction, and the final per-axis slew step into the
// velocity register that also drives out_tdata.
// Throughput is one item per clock unless out_tready holds results back, in
// which case empty stages still absorb new items. Write configuration only
// while no tick is in flight.
`default_nettype none

module velocity_command_slew_limiter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] time_us, [47:32] cmd_linear_x, [63:48] cmd_linear_y,
  // [79:64] cmd_angular_z
  input  logic [vcsl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] command (0 = new command, 1 = control tick)
  input  logic                               in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] out_linear_x, [33:17] out_linear_y, [50:34] out_angular_z,
  // [55:51] zero
  output logic [vcsl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [vcsl_pkg::CFG_A_W-1:0]       cfg_addr,
  input  logic [vcsl_pkg::CFG_W-1:0]         cfg_wdata
);

  // Configuration registers
  logic [vcsl_pkg::EN_W-1:0]    en_r;
  logic [vcsl_pkg::TIME_W-1:0]  timeout_r;
  logic [vcsl_pkg::MAX_W-1:0]   max_lin_r;
  logic [vcsl_pkg::MAX_W-1:0]   max_ang_r;
  logic [vcsl_pkg::RATE_W-1:0]  rate_r [vcsl_pkg::NUM_LANE];

  // Command / tick bookkeeping
  logic signed [vcsl_pkg::CMD_W-1:0] held_cmd_r [vcsl_pkg::NUM_AX];
  logic                              cmd_seen_r;
  logic [vcsl_pkg::TIME_W-1:0]       last_cmd_time_r;
  logic                              tick_seen_r;
  logic [vcsl_pkg::TIME_W-1:0]       last_tick_time_r;

  // Input field views
  logic [vcsl_pkg::TIME_W-1:0]       in_time;
  logic signed [vcsl_pkg::CMD_W-1:0] in_cmd [vcsl_pkg::NUM_AX];
  logic                              in_fire;
  logic                              in_is_tick;
  logic [vcsl_pkg::TIME_W-1:0]       tick_gap;
  logic [vcsl_pkg::TIME_W-1:0]       cmd_age;
  logic [vcsl_pkg::DT_W-1:0]         dt_nxt;
  logic                              zero_nxt;

  // Stage valids and ready chain
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

  // Stage A
  logic [vcsl_pkg::DT_W-1:0]         a_dt_r;
  logic                              a_zero_r;
  logic signed [vcsl_pkg::CMD_W-1:0] a_cmd_r [vcsl_pkg::NUM_AX];

  // Stage B
  logic [vcsl_pkg::PLO_W-1:0]        b_lo_r   [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::PHI_W-1:0]        b_hi_r   [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::PLO_W-1:0]        b_lo_nxt [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::PHI_W-1:0]        b_hi_nxt [vcsl_pkg::NUM_LANE];
  logic signed [vcsl_pkg::VEL_W-1:0] b_tgt_r   [vcsl_pkg::NUM_AX];
  logic signed [vcsl_pkg::VEL_W-1:0] b_tgt_nxt [vcsl_pkg::NUM_AX];
  logic [16:0]                       sc_mag   [vcsl_pkg::NUM_AX];
  logic [14:0]                       sc_clamp [vcsl_pkg::NUM_AX];
  logic [29:0]                       sc_prod  [vcsl_pkg::NUM_AX];
  logic [vcsl_pkg::MAX_W-1:0]        sc_max   [vcsl_pkg::NUM_AX];

  // Stage C
  logic [vcsl_pkg::PROD_W-1:0]       c_prod   [vcsl_pkg::NUM_LANE];
  logic                              c_sat_r  [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::X_W-1:0]          c_x_r    [vcsl_pkg::NUM_LANE];
  logic signed [vcsl_pkg::VEL_W-1:0] c_tgt_r  [vcsl_pkg::NUM_AX];

  // Stage D
  logic [vcsl_pkg::RQ_W-1:0]         d_rq     [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::LIM_W-1:0]        d_q_r    [vcsl_pkg::NUM_LANE];
  logic                              d_sat_r  [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::X_W-1:0]          d_x_r    [vcsl_pkg::NUM_LANE];
  logic signed [vcsl_pkg::VEL_W-1:0] d_tgt_r  [vcsl_pkg::NUM_AX];

  // Stage E
  logic [31:0]                       e_qd     [vcsl_pkg::NUM_LANE];
  logic [31:0]                       e_rem    [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::LIM_W-1:0]        e_qc     [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::LIM_W-1:0]        e_lim_nxt [vcsl_pkg::NUM_LANE];
  logic [vcsl_pkg::LIM_W-1:0]        e_lim_r  [vcsl_pkg::NUM_LANE];
  logic signed [vcsl_pkg::VEL_W-1:0] e_tgt_r  [vcsl_pkg::NUM_AX];

  // Output stage: smoothed velocity doubles as the result register
  logic signed [vcsl_pkg::VEL_W-1:0] sm_r   [vcsl_pkg::NUM_AX];
  logic signed [vcsl_pkg::VEL_W-1:0] sm_nxt [vcsl_pkg::NUM_AX];
  logic [vcsl_pkg::VEL_W-1:0]        sl_ac  [vcsl_pkg::NUM_AX];
  logic [vcsl_pkg::VEL_W-1:0]        sl_at  [vcsl_pkg::NUM_AX];
  logic                              sl_acc [vcsl_pkg::NUM_AX];
  logic [vcsl_pkg::LIM_W-1:0]        sl_lim [vcsl_pkg::NUM_AX];
  logic signed [18:0]                sl_lims [vcsl_pkg::NUM_AX];
  logic signed [18:0]                sl_diff [vcsl_pkg::NUM_AX];
  logic signed [18:0]                sl_dcl  [vcsl_pkg::NUM_AX];
  logic signed [18:0]                sl_sum  [vcsl_pkg::NUM_AX];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 2'd3;
      timeout_r <= 32'd500000;
      max_lin_r <= 16'd256;
      max_ang_r <= 16'd256;
      for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
        rate_r[k] <= 24'd256;
      end
    end else if (cfg_we) begin
      case (vcsl_pkg::cfg_reg_t'(cfg_addr))
        vcsl_pkg::REG_ENABLE_FLAGS: en_r <= cfg_wdata[vcsl_pkg::EN_W-1:0];
        vcsl_pkg::REG_TIMEOUT_US:   timeout_r <= cfg_wdata;
        vcsl_pkg::REG_MAX_LINEAR:   max_lin_r <= cfg_wdata[vcsl_pkg::MAX_W-1:0];
        vcsl_pkg::REG_MAX_ANGULAR:  max_ang_r <= cfg_wdata[vcsl_pkg::MAX_W-1:0];
        vcsl_pkg::REG_LIN_ACCEL:
          rate_r[vcsl_pkg::LANE_LIN_ACC] <= cfg_wdata[vcsl_pkg::RATE_W-1:0];
        vcsl_pkg::REG_LIN_DECEL:
          rate_r[vcsl_pkg::LANE_LIN_DEC] <= cfg_wdata[vcsl_pkg::RATE_W-1:0];
        vcsl_pkg::REG_ANG_ACCEL:
          rate_r[vcsl_pkg::LANE_ANG_ACC] <= cfg_wdata[vcsl_pkg::RATE_W-1:0];
        vcsl_pkg::REG_ANG_DECEL:
          rate_r[vcsl_pkg::LANE_ANG_DEC] <= cfg_wdata[vcsl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a new entry when empty or when it drains
  assign rdy_o     = !o_v_r || out_tready;
  assign rdy_e     = !e_v_r || rdy_o;
  assign rdy_d     = !d_v_r || rdy_e;
  assign rdy_c     = !c_v_r || rdy_d;
  assign rdy_b     = !b_v_r || rdy_c;
  assign rdy_a     = !a_v_r || rdy_b;
  assign in_tready = rdy_a;

  // Unpack input fields
  assign in_time    = in_tdata[31:0];
  assign in_cmd[0]  = in_tdata[47:32];
  assign in_cmd[1]  = in_tdata[63:48];
  assign in_cmd[2]  = in_tdata[79:64];
  assign in_fire    = in_tvalid && in_tready;
  assign in_is_tick = (vcsl_pkg::kind_t'(in_tuser) == vcsl_pkg::KIND_TICK);

  // Tick interval and command age
  always_comb begin
    tick_gap = in_time - last_tick_time_r;
    cmd_age  = in_time - last_cmd_time_r;
    if (!tick_seen_r || tick_gap == '0 || tick_gap[vcsl_pkg::TIME_W-1]) begin
      dt_nxt = vcsl_pkg::NOMINAL_PERIOD_US;
    end else begin
      dt_nxt = tick_gap[vcsl_pkg::DT_W-1:0];
    end
    zero_nxt = en_r[1] && (!cmd_seen_r || cmd_age > timeout_r);
  end

  // Hold command and tick history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_seen_r       <= 1'b0;
      last_cmd_time_r  <= '0;
      tick_seen_r      <= 1'b0;
      last_tick_time_r <= '0;
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        held_cmd_r[j] <= '0;
      end
    end else if (in_fire) begin
      if (in_is_tick) begin
        tick_seen_r      <= 1'b1;
        last_tick_time_r <= in_time;
      end else begin
        cmd_seen_r      <= 1'b1;
        last_cmd_time_r <= in_time;
        for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
          held_cmd_r[j] <= in_cmd[j];
        end
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_fire && in_is_tick;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_e) e_v_r <= d_v_r;
      if (rdy_o) o_v_r <= e_v_r;
    end
  end

  // Stage B: partial products of rate x dt, target scaling
  always_comb begin
    for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
      b_lo_nxt[k] = vcsl_pkg::PLO_W'(rate_r[k]) *
                    vcsl_pkg::PLO_W'(a_dt_r[vcsl_pkg::LO_W-1:0]);
      b_hi_nxt[k] = vcsl_pkg::PHI_W'(rate_r[k]) *
                    vcsl_pkg::PHI_W'(a_dt_r[vcsl_pkg::DT_W-1:vcsl_pkg::LO_W]);
    end
    for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
      sc_max[j]   = (j == vcsl_pkg::NUM_AX - 1) ? max_ang_r : max_lin_r;
      sc_mag[j]   = a_cmd_r[j][vcsl_pkg::CMD_W-1] ?
                    (17'd0 - {a_cmd_r[j][vcsl_pkg::CMD_W-1], a_cmd_r[j]}) :
                    {1'b0, a_cmd_r[j]};
      sc_clamp[j] = (sc_mag[j] > vcsl_pkg::ONE_Q14) ? vcsl_pkg::ONE_Q14[14:0] :
                                                      sc_mag[j][14:0];
      sc_prod[j]  = 30'(sc_clamp[j]) * 30'(sc_max[j]);
      if (a_zero_r) begin
        b_tgt_nxt[j] = '0;
      end else if (a_cmd_r[j][vcsl_pkg::CMD_W-1]) begin
        b_tgt_nxt[j] = 17'd0 - {1'b0, sc_prod[j][29:14]};
      end else begin
        b_tgt_nxt[j] = {1'b0, sc_prod[j][29:14]};
      end
    end
  end

  // Stage C: full product, saturation test, drop the factor 64 of 1e6
  always_comb begin
    for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
      c_prod[k] = vcsl_pkg::PROD_W'(b_lo_r[k]) + {b_hi_r[k], 16'd0};
    end
  end

  // Stage D: quotient estimate by reciprocal of 15625
  always_comb begin
    for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
      d_rq[k] = vcsl_pkg::RQ_W'(c_x_r[k]) * vcsl_pkg::RQ_W'(vcsl_pkg::RECIP_DIV);
    end
  end

  // Stage E: correct the estimate, clamp to the saturation limit
  always_comb begin
    for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
      e_qd[k]  = 32'(d_q_r[k]) * 32'(vcsl_pkg::DIV_CONST);
      e_rem[k] = {1'b0, d_x_r[k]} - e_qd[k];
      e_qc[k]  = (e_rem[k] >= 32'(vcsl_pkg::DIV_CONST)) ? d_q_r[k] + 18'd1 : d_q_r[k];
      e_lim_nxt[k] = (d_sat_r[k] || e_qc[k] > vcsl_pkg::LIM_SAT) ? vcsl_pkg::LIM_SAT :
                                                                  e_qc[k];
    end
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_dt_r   <= dt_nxt;
      a_zero_r <= zero_nxt;
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        a_cmd_r[j] <= held_cmd_r[j];
      end
    end
    if (rdy_b) begin
      for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
        b_lo_r[k] <= b_lo_nxt[k];
        b_hi_r[k] <= b_hi_nxt[k];
      end
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        b_tgt_r[j] <= b_tgt_nxt[j];
      end
    end
    if (rdy_c) begin
      for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
        c_sat_r[k] <= |c_prod[k][vcsl_pkg::PROD_W-1:37];
        c_x_r[k]   <= c_prod[k][36:6];
      end
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        c_tgt_r[j] <= b_tgt_r[j];
      end
    end
    if (rdy_d) begin
      for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
        d_q_r[k]   <= d_rq[k][vcsl_pkg::RQ_W-1:31];
        d_x_r[k]   <= c_x_r[k];
        d_sat_r[k] <= c_sat_r[k];
      end
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        d_tgt_r[j] <= c_tgt_r[j];
      end
    end
    if (rdy_e) begin
      for (int k = 0; k < vcsl_pkg::NUM_LANE; k++) begin
        e_lim_r[k] <= e_lim_nxt[k];
      end
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        e_tgt_r[j] <= d_tgt_r[j];
      end
    end
  end

  // Slew each axis toward its target by at most the step limit
  always_comb begin
    for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
      sl_ac[j]  = sm_r[j][vcsl_pkg::VEL_W-1] ? 17'd0 - sm_r[j] : sm_r[j];
      sl_at[j]  = e_tgt_r[j][vcsl_pkg::VEL_W-1] ? 17'd0 - e_tgt_r[j] : e_tgt_r[j];
      // growing magnitude without a sign flip uses the accel limit
      sl_acc[j] = (sl_at[j] >= sl_ac[j]) &&
                  !((sm_r[j] < 0 && e_tgt_r[j] > 0) || (sm_r[j] > 0 && e_tgt_r[j] < 0));
      if (j == vcsl_pkg::NUM_AX - 1) begin
        sl_lim[j] = sl_acc[j] ? e_lim_r[vcsl_pkg::LANE_ANG_ACC] :
                                e_lim_r[vcsl_pkg::LANE_ANG_DEC];
      end else begin
        sl_lim[j] = sl_acc[j] ? e_lim_r[vcsl_pkg::LANE_LIN_ACC] :
                                e_lim_r[vcsl_pkg::LANE_LIN_DEC];
      end
      sl_lims[j] = $signed({1'b0, sl_lim[j]});
      sl_diff[j] = 19'(e_tgt_r[j]) - 19'(sm_r[j]);
      if (sl_diff[j] > sl_lims[j]) begin
        sl_dcl[j] = sl_lims[j];
      end else if (sl_diff[j] < -sl_lims[j]) begin
        sl_dcl[j] = -sl_lims[j];
      end else begin
        sl_dcl[j] = sl_diff[j];
      end
      sl_sum[j] = 19'(sm_r[j]) + sl_dcl[j];
      sm_nxt[j] = en_r[0] ? sl_sum[j][vcsl_pkg::VEL_W-1:0] : e_tgt_r[j];
    end
  end

  // Update smoothed velocity when a tick reaches the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        sm_r[j] <= '0;
      end
    end else if (rdy_o && e_v_r) begin
      for (int j = 0; j < vcsl_pkg::NUM_AX; j++) begin
        sm_r[j] <= sm_nxt[j];
      end
    end
  end

  // Drive result stream
  assign out_tvalid = o_v_r;
  assign out_tdata  = {(vcsl_pkg::OUT_TDATA_W - vcsl_pkg::OUT_FIELD_W)'(0),
                       sm_r[2], sm_r[1], sm_r[0]};

endmodule

`default_nettype wire

[src/vcsl_checker.sv]
// ----------------------------------------------------------------------------
// vcsl_checker
// Port-level checks for the velocity command slew limiter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vcsl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with no stalled result");

  // Velocities stay within +-65535 and padding stays zero
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:51] == 5'd0 &&
                   out_tdata[16:0] != 17'h10000 &&
                   out_tdata[33:17] != 17'h10000 &&
                   out_tdata[50:34] != 17'h10000)
    else $error("result velocity out of range");

endmodule

bind velocity_command_slew_limiter_unit vcsl_checker u_vcsl_checker (.*);

`default_nettype wire

[verif/tb_velocity_command_slew_limiter_unit.sv]
// ----------------------------------------------------------------------------
// tb_velocity_command_slew_limiter_unit
// Self-checking testbench for the velocity command slew limiter. A scoreboard
// tracks the held command, the tick timing and the smoothed velocity, and
// predicts the result of every tick transfer. Directed items cover the
// clamping, timing and timeout corner cases. Random items then run under
// several register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected result of one tick, lowest field in the lowest bits
typedef struct packed {
  logic [16:0] ang_z;
  logic [16:0] lin_y;
  logic [16:0] lin_x;
} velocity_t;

class velocity_scoreboard;
  // Register copies
  logic [1:0]  flags;
  logic [31:0] timeout_us;
  logic [15:0] max_lin;
  logic [15:0] max_ang;
  logic [23:0] lin_acc;
  logic [23:0] lin_dec;
  logic [23:0] ang_acc;
  logic [23:0] ang_dec;
  // Block state
  int          held_cmd [3];
  bit          cmd_seen;
  logic [31:0] cmd_time;
  bit          tick_seen;
  logic [31:0] tick_time;
  int          velocity [3];
  // Results still owed by the block
  velocity_t   expected_q [$];
  int          error_count;

  function new();
    flags       = 2'd3;
    timeout_us  = 32'd500000;
    max_lin     = 16'd256;
    max_ang     = 16'd256;
    lin_acc     = 24'd256;
    lin_dec     = 24'd256;
    ang_acc     = 24'd256;
    ang_dec     = 24'd256;
    foreach (held_cmd[i]) begin
      held_cmd[i] = 0;
      velocity[i] = 0;
    end
    cmd_seen    = 1'b0;
    cmd_time    = '0;
    tick_seen   = 1'b0;
    tick_time   = '0;
    error_count = 0;
  endfunction

  function void set_reg(vcsl_pkg::cfg_reg_t idx, logic [31:0] value);
    case (idx)
      vcsl_pkg::REG_ENABLE_FLAGS: flags      = value[1:0];
      vcsl_pkg::REG_TIMEOUT_US:   timeout_us = value;
      vcsl_pkg::REG_MAX_LINEAR:   max_lin    = value[15:0];
      vcsl_pkg::REG_MAX_ANGULAR:  max_ang    = value[15:0];
      vcsl_pkg::REG_LIN_ACCEL:    lin_acc    = value[23:0];
      vcsl_pkg::REG_LIN_DECEL:    lin_dec    = value[23:0];
      vcsl_pkg::REG_ANG_ACCEL:    ang_acc    = value[23:0];
      vcsl_pkg::REG_ANG_DECEL:    ang_dec    = value[23:0];
      default: ;
    endcase
  endfunction

  // Clamp a Q2.14 command to +-1.0 and scale to Q8.8, truncating toward zero
  function int scaled_target(int cmd, logic [15:0] full_scale);
    longint mag;
    mag = (cmd < 0) ? -cmd : cmd;
    if (mag > 16384) mag = 16384;
    mag = (mag * longint'(full_scale)) >> 14;
    return (cmd < 0) ? -int'(mag) : int'(mag);
  endfunction

  // Largest change allowed this tick: floor(rate * dt / 1e6), saturated
  function longint step_limit(logic [23:0] rate, int unsigned dt);
    longint lim;
    lim = (longint'(rate) * longint'(dt)) / 1000000;
    if (lim > 131072) lim = 131072;
    return lim;
  endfunction

  // Move one axis toward its target without overshoot
  function int slew_axis(int cur, int tgt, longint up, longint down);
    int     mag_cur;
    int     mag_tgt;
    bit     same_sign;
    longint lim;
    longint delta;
    mag_cur   = (cur < 0) ? -cur : cur;
    mag_tgt   = (tgt < 0) ? -tgt : tgt;
    same_sign = !((cur < 0 && tgt > 0) || (cur > 0 && tgt < 0));
    lim       = (mag_tgt >= mag_cur && same_sign) ? up : down;
    delta     = longint'(tgt) - longint'(cur);
    if (delta > lim) delta = lim;
    if (delta < -lim) delta = -lim;
    return cur + int'(delta);
  endfunction

  // Advance the state on one input transfer; a tick owes one result
  function void note_input(vcsl_pkg::kind_t kind, logic [79:0] data);
    logic [31:0] now;
    logic [31:0] gap;
    int unsigned dt;
    int          tgt [3];
    velocity_t   want;
    now = data[31:0];
    if (kind == vcsl_pkg::KIND_COMMAND) begin
      held_cmd[0] = int'($signed(data[47:32]));
      held_cmd[1] = int'($signed(data[63:48]));
      held_cmd[2] = int'($signed(data[79:64]));
      cmd_time    = now;
      cmd_seen    = 1'b1;
    end else begin
      // Fall back to the nominal period on the first tick or a non-positive gap
      gap = now - tick_time;
      if (!tick_seen || gap == '0 || gap[31])
        dt = int'(vcsl_pkg::NOMINAL_PERIOD_US);
      else
        dt = gap;
      tick_seen = 1'b1;
      tick_time = now;
      // With the timeout enabled, zero the target when no command arrived or it went stale
      if (flags[1] && (!cmd_seen || (now - cmd_time) > timeout_us)) begin
        tgt[0] = 0;
        tgt[1] = 0;
        tgt[2] = 0;
      end else begin
        tgt[0] = scaled_target(held_cmd[0], max_lin);
        tgt[1] = scaled_target(held_cmd[1], max_lin);
        tgt[2] = scaled_target(held_cmd[2], max_ang);
      end
      if (!flags[0]) begin
        foreach (velocity[i]) velocity[i] = tgt[i];
      end else begin
        velocity[0] = slew_axis(velocity[0], tgt[0], step_limit(lin_acc, dt),
                                step_limit(lin_dec, dt));
        velocity[1] = slew_axis(velocity[1], tgt[1], step_limit(lin_acc, dt),
                                step_limit(lin_dec, dt));
        velocity[2] = slew_axis(velocity[2], tgt[2], step_limit(ang_acc, dt),
                                step_limit(ang_dec, dt));
      end
      want.lin_x = 17'(velocity[0]);
      want.lin_y = 17'(velocity[1]);
      want.ang_z = 17'(velocity[2]);
      expected_q = {expected_q, want};
    end
  endfunction

  task report(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  task compare_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      report($sformatf("%s: got %0d, expected %0d", name, $signed(got), $signed(want)));
  endtask

  // Compare one result transfer with the oldest expectation
  task check_result(logic [55:0] data);
    velocity_t got;
    velocity_t want;
    got = data[50:0];
    if (expected_q.size() == 0) begin
      report($sformatf("result %h with no tick outstanding", data));
    end else begin
      want = expected_q.pop_front();
      compare_field("out_linear_x", got.lin_x, want.lin_x);
      compare_field("out_linear_y", got.lin_y, want.lin_y);
      compare_field("out_angular_z", got.ang_z, want.ang_z);
      if (data[55:51] !== '0)
        report($sformatf("padding bits %b not zero", data[55:51]));
    end
  endtask

  task close_out();
    if (expected_q.size() != 0)
      report($sformatf("%0d results never arrived", expected_q.size()));
  endtask
endclass

module tb_velocity_command_slew_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 12;
  localparam int STALL_LIMIT     = 2000;

  typedef struct {
    logic [1:0]  flags;
    logic [31:0] timeout_us;
    logic [15:0] max_lin;
    logic [15:0] max_ang;
    logic [23:0] lin_acc;
    logic [23:0] lin_dec;
    logic [23:0] ang_acc;
    logic [23:0] ang_dec;
  } settings_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [vcsl_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [vcsl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_we;
  logic [vcsl_pkg::CFG_A_W-1:0]     cfg_addr;
  logic [vcsl_pkg::CFG_W-1:0]       cfg_wdata;

  velocity_scoreboard     sb;
  logic [31:0]            now_us;
  bit                     no_idle = 1'b0;
  int                     quiet_cycles = 0;

  velocity_command_slew_limiter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Monitor both streams and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(vcsl_pkg::kind_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("velocity_command_slew_limiter_unit test failed");
        $finish;
      end
    end
  end

  // Result side: ready with random stall bursts, none in the last phase
  initial begin : result_sink
    int n;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
  end

  // Hold one item on the input stream until its transfer
  task automatic send_item(vcsl_pkg::kind_t kind, logic [31:0] t, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {z, y, x, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(vcsl_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(vcsl_pkg::REG_ENABLE_FLAGS, 32'(s.flags));
    write_reg(vcsl_pkg::REG_TIMEOUT_US, s.timeout_us);
    write_reg(vcsl_pkg::REG_MAX_LINEAR, 32'(s.max_lin));
    write_reg(vcsl_pkg::REG_MAX_ANGULAR, 32'(s.max_ang));
    write_reg(vcsl_pkg::REG_LIN_ACCEL, 32'(s.lin_acc));
    write_reg(vcsl_pkg::REG_LIN_DECEL, 32'(s.lin_dec));
    write_reg(vcsl_pkg::REG_ANG_ACCEL, 32'(s.ang_acc));
    write_reg(vcsl_pkg::REG_ANG_DECEL, 32'(s.ang_dec));
    cfg_we <= 1'b0;
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_rate();
    if ($urandom_range(0, 1) == 0) return 24'($urandom);
    return 24'($urandom_range(20000, 4000000));
  endfunction

  function automatic settings_t phase_settings(int phase);
    settings_t s;
    case (phase)
      // Everything at its top value but a zero timeout
      1: s = '{2'd3, 32'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               24'hFFFFFF};
      // Mostly bottom values, a top timeout and lopsided rates
      2: s = '{2'd1, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 24'd0, 24'hFFFFFF, 24'd1, 24'd0};
      default: begin
        s.flags      = (phase < 7) ? 2'(phase) : 2'($urandom_range(0, 3));
        s.timeout_us = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(20000, 300000);
        s.max_lin    = 16'($urandom);
        s.max_ang    = 16'($urandom);
        s.lin_acc    = rand_rate();
        s.lin_dec    = rand_rate();
        s.ang_acc    = rand_rate();
        s.ang_dec    = rand_rate();
      end
    endcase
    return s;
  endfunction

  function automatic logic [15:0] rand_cmd();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 6))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h4000;
          3:       return 16'hC000;
          4:       return 16'h4001;
          5:       return 16'hBFFF;
          default: return 16'h0000;
        endcase
      end
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Mostly near the control period, with repeats, steps back, long gaps, jumps and short gaps
  function automatic logic [31:0] next_time(logic [31:0] t);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return t + $urandom_range(15000, 25000);
    if (r < 68) return t;
    if (r < 76) return t - $urandom_range(1, 60000);
    if (r < 86) return t + $urandom_range(100000, 1200000);
    if (r < 92) return $urandom;
    return t + $urandom_range(1, 500);
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      now_us = next_time(now_us);
      if ($urandom_range(0, 9) < 3)
        send_item(vcsl_pkg::KIND_COMMAND, now_us, rand_cmd(), rand_cmd(), rand_cmd());
      else
        send_item(vcsl_pkg::KIND_TICK, now_us, 16'($urandom), 16'($urandom),
                  16'($urandom));
    end
  endtask

  // Corner cases under the reset settings
  task automatic run_directed();
    // First tick before any command: timed-out target, nominal dt
    send_item(vcsl_pkg::KIND_TICK, 32'd1000, 16'h0000, 16'h0000, 16'h0000);
    // Beyond full scale and full scale clamp to +-1.0
    send_item(vcsl_pkg::KIND_COMMAND, 32'd2000, 16'h7FFF, 16'h8000, 16'h4000);
    send_item(vcsl_pkg::KIND_TICK, 32'd22000, 16'h0000, 16'h0000, 16'h0000);
    // Zero gap, then a step back in time
    send_item(vcsl_pkg::KIND_TICK, 32'd22000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(vcsl_pkg::KIND_TICK, 32'd10000, 16'h0000, 16'h0000, 16'h0000);
    // Command age equal to the timeout, then one past it
    send_item(vcsl_pkg::KIND_TICK, 32'd502000, 16'h0000, 16'h0000, 16'h0000);
    send_item(vcsl_pkg::KIND_TICK, 32'd502001, 16'h0000, 16'h0000, 16'h0000);
    // Sign flip over a one-second gap
    send_item(vcsl_pkg::KIND_COMMAND, 32'd502001, 16'hC000, 16'h3FFF, 16'hFFFF);
    send_item(vcsl_pkg::KIND_TICK, 32'd1502001, 16'h0000, 16'h0000, 16'h0000);
    send_item(vcsl_pkg::KIND_TICK, 32'd1522001, 16'h0000, 16'h0000, 16'h0000);
    // Timestamps wrapping past 2^32
    send_item(vcsl_pkg::KIND_COMMAND, 32'hFFFF_FF00, 16'h8001, 16'h0000, 16'h8000);
    send_item(vcsl_pkg::KIND_TICK, 32'h0000_0100, 16'h0000, 16'h0000, 16'h0000);
    // Largest positive gap saturates the limit, half-range gap counts as negative
    send_item(vcsl_pkg::KIND_TICK, 32'h8000_00FF, 16'h0000, 16'h0000, 16'h0000);
    send_item(vcsl_pkg::KIND_TICK, 32'h0000_00FF, 16'h0000, 16'h0000, 16'h0000);
    send_item(vcsl_pkg::KIND_COMMAND, 32'h0000_0100, 16'h4001, 16'hBFFF, 16'h7FFF);
    send_item(vcsl_pkg::KIND_TICK, 32'h0000_5000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    now_us = 32'h0000_5000;
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= vcsl_pkg::REG_ENABLE_FLAGS;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    now_us     = '0;
    sb         = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings first, then one register setting per phase
    run_directed();
    random_items(ITEMS_PER_PHASE);
    for (int p = 1; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1) no_idle = 1'b1;
      apply_settings(phase_settings(p));
      random_items(ITEMS_PER_PHASE);
    end
    drain();
    sb.close_out();

    if (sb.error_count == 0)
      $display("velocity_command_slew_limiter_unit test passed");
    else
      $display("velocity_command_slew_limiter_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
